@@ rtl/prba_pkg.sv @@
// types, constants and codes for the page run bitmap allocator
// no dependencies
`default_nettype none

package prba_pkg;

  localparam int MAX_PAGES  = 64;
  localparam int PAGE_BYTES = 4096;
  localparam int FRAME_W    = 52;
  localparam int BYTES_W    = 19;
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int WINDOW_W   = 7;
  localparam int PAGE_OFS_W = $clog2(PAGE_BYTES);
  localparam int REQ_PAGES_W = BYTES_W + 1 - PAGE_OFS_W;
  localparam int ROW_BITS   = 8;
  localparam int ROW_SHIFT  = $clog2(ROW_BITS);
  localparam int ROWS       = MAX_PAGES / ROW_BITS;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 5;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(45);

  typedef enum logic [1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE_VIRT  = 2'd1,
    CMD_ALLOC_PAGE = 2'd2,
    CMD_FREE_PHYS  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_BAD  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_PHYS_BASE = 2'd0,
    REG_VIRT_BASE = 2'd1,
    REG_WINDOW    = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [BYTES_W-1:0]   byte_count;
    logic [FRAME_W-1:0]   frame_number;
  } req_word_t;

  typedef struct packed {
    status_t              status;
    logic [PAGE_W-1:0]    page_index;
    logic [FRAME_W-1:0]   phys_frame;
    logic [FRAME_W-1:0]   virt_frame;
  } rsp_word_t;

endpackage

`default_nettype wire

@@ rtl/page_run_bitmap_allocator.sv @@
// first-fit page run allocator over a bitmap held in a synchronous row memory
// depends on prba_pkg
`default_nettype none

// The in-use bitmap lives in an 8 x 8-bit synchronous RAM, one row per eight
// pages, and is read, modified and written back one row per cycle. Row valid
// flags cleared by reset make unwritten rows read as free, so there is no
// clearing pass after reset. An allocate is accepted, then scans row by row
// until the first fitting run is found (at most 8 rows), rewrites each row
// the run touches, and posts the result. A release skips the scan. Rejected
// requests go straight to posting the result. One request is in flight at a
// time; the result register lets the next request in while a result waits.
module page_run_bitmap_allocator import prba_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_word_t         req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_word_t              rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [FRAME_W-1:0]  phys_base;
  logic [FRAME_W-1:0]  virt_base;
  logic [WINDOW_W-1:0] window_pages;
  logic [CNT_W-1:0]    win;
  reg_index_t          reg_index;

  state_t state, state_next;

  logic [ROW_BITS-1:0] bitmap_mem [ROWS];
  logic [ROWS-1:0]     row_valid;
  logic [ROW_BITS-1:0] rdata;
  logic                rd_valid;
  logic [ROW_BITS-1:0] rdata_eff;
  logic                mem_ren, mem_we;
  logic [ROW_W-1:0]    mem_raddr;
  logic [ROW_BITS-1:0] mem_wdata;

  logic [ROW_W-1:0]    row;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    run_len;
  logic [CNT_W-1:0]    run_start;
  logic [PAGE_W-1:0]   start;
  logic                set_bits;
  status_t             status;

  logic                   req_fire;
  logic                   rsp_free;
  logic                   is_alloc;
  logic [BYTES_W:0]       byte_sum;
  logic [REQ_PAGES_W-1:0] count_in;
  logic [REQ_PAGES_W-1:0] win_ext;
  logic [FRAME_W-1:0]     rel_idx;
  logic                   idx_ok;
  logic                   alloc_bad, rel_bad, req_bad;

  logic [CNT_W-1:0]    scan_len, scan_st, page_pos;
  logic                scan_hit, scan_last;
  logic [ROW_W:0]      row_inc;
  logic [CNT_W-1:0]    next_base;
  logic [CNT_W-1:0]    run_end;
  logic [CNT_W-1:0]    run_last;
  logic [ROW_BITS-1:0] fill_mask;

  assign win       = (window_pages > WINDOW_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
                                                           : CNT_W'(window_pages);
  assign reg_index = reg_index_t'(paddr[ADDR_W-1:3]);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phys_base    <= '0;
      virt_base    <= '0;
      window_pages <= WINDOW_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_PHYS_BASE: phys_base    <= pwdata[FRAME_W-1:0];
        REG_VIRT_BASE: virt_base    <= pwdata[FRAME_W-1:0];
        REG_WINDOW:    window_pages <= pwdata[WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_PHYS_BASE: prdata = DATA_W'(phys_base);
      REG_VIRT_BASE: prdata = DATA_W'(virt_base);
      REG_WINDOW:    prdata = DATA_W'(window_pages);
      default:       prdata = '0;
    endcase
  end

  // request decode
  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign is_alloc  = (req.cmd == CMD_ALLOC) || (req.cmd == CMD_ALLOC_PAGE);
  assign byte_sum  = {1'b0, req.byte_count} + (BYTES_W + 1)'(PAGE_BYTES - 1);
  assign count_in  = ((req.cmd == CMD_ALLOC_PAGE) || (req.cmd == CMD_FREE_PHYS))
                     ? REQ_PAGES_W'(1) : byte_sum[BYTES_W:PAGE_OFS_W];
  assign win_ext   = REQ_PAGES_W'(win);
  assign rel_idx   = req.frame_number
                     - ((req.cmd == CMD_FREE_PHYS) ? phys_base : virt_base);
  assign idx_ok    = rel_idx < FRAME_W'(win);
  assign alloc_bad = (count_in == '0) || (count_in > win_ext);
  assign rel_bad   = (count_in == '0) || !idx_ok
                     || (count_in > (win_ext - REQ_PAGES_W'(rel_idx[CNT_W-1:0])));
  assign req_bad   = is_alloc ? alloc_bad : rel_bad;

  // bitmap row memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap_mem[row] <= mem_wdata;
    end
    if (mem_ren) begin
      rdata    <= bitmap_mem[mem_raddr];
      rd_valid <= row_valid[mem_raddr];
    end
  end

  assign rdata_eff = rd_valid ? rdata : '0;

  // one row of the first-fit scan
  always_comb begin
    scan_len = run_len;
    scan_st  = run_start;
    scan_hit = 1'b0;
    page_pos = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      page_pos = CNT_W'({row, ROW_SHIFT'(j)});
      if (!scan_hit && (page_pos < win)) begin
        if (rdata_eff[j]) begin
          scan_len = '0;
          scan_st  = page_pos + CNT_W'(1);
        end else begin
          scan_len = scan_len + CNT_W'(1);
          if (scan_len == count) begin
            scan_hit = 1'b1;
          end
        end
      end
    end
  end

  assign row_inc   = {1'b0, row} + (ROW_W + 1)'(1);
  assign next_base = CNT_W'({row_inc, ROW_SHIFT'(0)});
  assign scan_last = next_base >= win;

  // run mask for the row being rewritten
  assign run_end  = CNT_W'(start) + count;
  assign run_last = run_end - CNT_W'(1);

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      fill_mask[j] = (CNT_W'({row, ROW_SHIFT'(j)}) >= CNT_W'(start))
                     && (CNT_W'({row, ROW_SHIFT'(j)}) < run_end);
    end
  end

  assign mem_wdata = set_bits ? (rdata_eff | fill_mask) : (rdata_eff & ~fill_mask);

  always_comb begin
    state_next = state;
    mem_ren    = 1'b0;
    mem_raddr  = row;
    mem_we     = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          if (req_bad) begin
            state_next = S_DONE;
          end else if (is_alloc) begin
            mem_ren    = 1'b1;
            mem_raddr  = '0;
            state_next = S_SCAN;
          end else begin
            mem_ren    = 1'b1;
            mem_raddr  = rel_idx[PAGE_W-1:ROW_SHIFT];
            state_next = S_FILL;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          mem_ren    = 1'b1;
          mem_raddr  = scan_st[PAGE_W-1:ROW_SHIFT];
          state_next = S_FILL;
        end else if (scan_last) begin
          state_next = S_DONE;
        end else begin
          mem_ren   = 1'b1;
          mem_raddr = row_inc[ROW_W-1:0];
        end
      end
      S_FILL: begin
        mem_we = 1'b1;
        if (row == run_last[PAGE_W-1:ROW_SHIFT]) begin
          state_next = S_DONE;
        end else begin
          mem_ren   = 1'b1;
          mem_raddr = row_inc[ROW_W-1:0];
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (mem_we) begin
      row_valid[row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_fire) begin
          count     <= count_in[CNT_W-1:0];
          set_bits  <= is_alloc;
          run_len   <= '0;
          run_start <= '0;
          status    <= req_bad ? STATUS_BAD : STATUS_OK;
          start     <= rel_idx[PAGE_W-1:0];
          row       <= is_alloc ? '0 : rel_idx[PAGE_W-1:ROW_SHIFT];
        end
      end
      S_SCAN: begin
        run_len   <= scan_len;
        run_start <= scan_st;
        if (scan_hit) begin
          start <= scan_st[PAGE_W-1:0];
          row   <= scan_st[PAGE_W-1:ROW_SHIFT];
        end else begin
          row <= row_inc[ROW_W-1:0];
          if (scan_last) begin
            status <= STATUS_FULL;
          end
        end
      end
      S_FILL: begin
        row <= row_inc[ROW_W-1:0];
      end
      default: ;
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == S_DONE) && rsp_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && rsp_free) begin
      rsp.status <= status;
      if (status == STATUS_OK) begin
        rsp.page_index <= start;
        rsp.phys_frame <= phys_base + FRAME_W'(start);
        rsp.virt_frame <= virt_base + FRAME_W'(start);
      end else begin
        rsp.page_index <= '0;
        rsp.phys_frame <= '0;
        rsp.virt_frame <= '0;
      end
    end
  end

endmodule

`default_nettype wire
